>>> rtl/point_in_polygon_test_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the point-in-polygon checker
// Each macro expects clk and arst_n in scope at the place of use.
// ----------------------------------------------------------------------------
`ifndef POINT_IN_POLYGON_TEST_MACROS_SVH
`define POINT_IN_POLYGON_TEST_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define PIP_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("point_in_polygon_test: assertion failed");

// Next-cycle implication, sampled on the rising clock edge.
`define PIP_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("point_in_polygon_test: assertion failed");

`endif

>>> rtl/pip_pkg.sv
// ----------------------------------------------------------------------------
// pip_pkg
// Shared types and constants of the point-in-polygon test block.
// ----------------------------------------------------------------------------
package pip_pkg;

	localparam int OP_W       = 2;
	localparam int COORD_W    = 32;
	localparam int CROSS_W    = 8;
	localparam int IN_DATA_W  = 2 * COORD_W;
	localparam int OUT_DATA_W = 16;
	localparam int OUT_PAD_W  = OUT_DATA_W - CROSS_W - 2;

	// Opcodes carried in tuser; the fourth code is reserved and only returns a zero result.
	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
	localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_DONE
	} state_t;

endpackage

>>> rtl/pip_ram.sv
// ----------------------------------------------------------------------------
// pip_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pip_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/point_in_polygon_test.sv
// ----------------------------------------------------------------------------
// point_in_polygon_test
// Crossing-number point-in-polygon test over a stored (r, z) vertex outline.
// Clear, append, reserved code: DONE loads the output register when it is free.
// Query over N stored vertices: RUN makes one vertex read per cycle from the
// vertex RAM, DRAIN empties the pipeline, then DONE; N below 2 goes to DONE.
// One item at a time; the next input is taken once the result has moved to
// the output register. Reset empties the outline; RAM contents are not reset.
// ----------------------------------------------------------------------------
module point_in_polygon_test #(
	parameter int MAX_VERTICES = 256
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// [31:0] coord_r, [63:32] coord_z
	input  logic [pip_pkg::IN_DATA_W-1:0]    s_tdata,
	// [1:0] opcode
	input  logic [pip_pkg::OP_W-1:0]         s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [0] inside_res, [8:1] crossings, [9] status, [15:10] zero
	output logic [pip_pkg::OUT_DATA_W-1:0]   m_tdata
);

	import pip_pkg::*;

	localparam int ADDR_W = $clog2(MAX_VERTICES);
	localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
	localparam int HIT_W  = ADDR_W;
	localparam int MEM_W  = 2 * COORD_W;
	localparam int SH_W   = COORD_W + 1;
	localparam int PROD_W = 2 * SH_W;
	localparam int DIFF_W = PROD_W + 1;

	state_t state_q, state_d;

	logic                     in_xfer;
	logic [OP_W-1:0]          op;
	logic [COORD_W-1:0]       in_r, in_z;
	logic                     store_full, few_verts, last_rd, out_free, load_out;
	logic                     ram_we, ram_re;
	logic [MEM_W-1:0]         ram_rdata;

	logic [CNT_W-1:0]         count_q;
	logic [ADDR_W-1:0]        rd_addr_q;
	logic signed [COORD_W-1:0] qr_q, qz_q;
	logic [HIT_W-1:0]         hits_q;
	logic                     drop_q;

	logic                     v_s1, first_s1;
	logic signed [SH_W-1:0]   r1_q, z1_q, r2, z2;
	logic                     v_s2, opp_s2, z1pos_s2;
	logic signed [PROD_W-1:0] p1_s2, p2_s2;
	logic signed [DIFF_W-1:0] diff;
	logic                     hit;

	logic [HIT_W+CROSS_W-1:0] hits_ext;
	logic [CROSS_W-1:0]       cross_sat;
	logic                     m_tvalid_q;
	logic [OUT_DATA_W-1:0]    m_tdata_q;

	assign op      = s_tuser;
	assign in_r    = s_tdata[COORD_W-1:0];
	assign in_z    = s_tdata[MEM_W-1:COORD_W];
	assign in_xfer = s_tvalid && s_tready;

	assign store_full = (count_q == CNT_W'(MAX_VERTICES));
	assign few_verts  = (count_q < CNT_W'(2));
	assign last_rd    = ((CNT_W'(rd_addr_q) + CNT_W'(1)) == count_q);
	assign out_free   = !m_tvalid_q || m_tready;

	// Appends and queries never overlap, so no forwarding path is needed.
	assign ram_we = in_xfer && (op == OP_APPEND) && !store_full;

	pip_ram #(
		.WIDTH (MEM_W),
		.DEPTH (MAX_VERTICES)
	) u_vert_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[ADDR_W-1:0]),
		.wdata ({in_z, in_r}),
		.re    (ram_re),
		.raddr (rd_addr_q),
		.rdata (ram_rdata)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					state_d = ((op == OP_QUERY) && !few_verts) ? ST_RUN : ST_DONE;
				end
			end
			ST_RUN: begin
				if (last_rd) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!v_s1 && !v_s2) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		s_tready = 1'b0;
		ram_re   = 1'b0;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE:  s_tready = 1'b1;
			ST_RUN:   ram_re   = 1'b1;
			ST_DRAIN: ;
			ST_DONE:  load_out = out_free;
			default:  ;
		endcase
	end

	// Shift the fresh vertex to the query origin
	assign r2 = $signed({ram_rdata[COORD_W-1], ram_rdata[COORD_W-1:0]})
		- $signed({qr_q[COORD_W-1], qr_q});
	assign z2 = $signed({ram_rdata[MEM_W-1], ram_rdata[MEM_W-1:COORD_W]})
		- $signed({qz_q[COORD_W-1], qz_q});

	// Sign of z1*r2 - r1*z2 decides the crossing side
	assign diff = $signed({p1_s2[PROD_W-1], p1_s2}) - $signed({p2_s2[PROD_W-1], p2_s2});
	assign hit  = v_s2 && opp_s2
		&& (z1pos_s2 ? (!diff[DIFF_W-1] && (diff != '0)) : diff[DIFF_W-1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			rd_addr_q  <= '0;
			hits_q     <= '0;
			drop_q     <= 1'b0;
			v_s1       <= 1'b0;
			first_s1   <= 1'b0;
			v_s2       <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			v_s1     <= ram_re;
			first_s1 <= (rd_addr_q == '0);
			v_s2     <= v_s1 && !first_s1;
			if (in_xfer) begin
				rd_addr_q <= '0;
				hits_q    <= '0;
				drop_q    <= (op == OP_APPEND) && store_full;
				if (op == OP_CLEAR) begin
					count_q <= '0;
				end else if (ram_we) begin
					count_q <= count_q + CNT_W'(1);
				end
			end else begin
				if (ram_re) begin
					rd_addr_q <= rd_addr_q + ADDR_W'(1);
				end
				if (hit) begin
					hits_q <= hits_q + HIT_W'(1);
				end
			end
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			qr_q <= $signed(in_r);
			qz_q <= $signed(in_z);
		end
		if (v_s1) begin
			// Hold the current vertex as the start of the next edge
			r1_q     <= r2;
			z1_q     <= z2;
			p1_s2    <= z1_q * r2;
			p2_s2    <= r1_q * z2;
			opp_s2   <= ((z1_q > 0) && (z2 < 0)) || ((z1_q < 0) && (z2 > 0));
			z1pos_s2 <= (z1_q > 0);
		end
	end

	// Saturate the count at the field width
	assign hits_ext  = {{CROSS_W{1'b0}}, hits_q};
	assign cross_sat = (hits_ext > (HIT_W+CROSS_W)'(255)) ? '1 : hits_ext[CROSS_W-1:0];

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_tdata_q <= {{OUT_PAD_W{1'b0}}, drop_q, cross_sat, hits_q[0]};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

>>> rtl/pip_chk.sv
// ----------------------------------------------------------------------------
// pip_chk
// Port-level checker for point_in_polygon_test, bound to the top level.
// ----------------------------------------------------------------------------
`include "point_in_polygon_test_macros.svh"

module pip_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic [pip_pkg::IN_DATA_W-1:0]  s_tdata,
	input logic [pip_pkg::OP_W-1:0]       s_tuser,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [pip_pkg::OUT_DATA_W-1:0] m_tdata
);

	import pip_pkg::*;

	logic [CROSS_W-1:0] cross_cnt;
	logic               pad_clear;

	assign cross_cnt = m_tdata[CROSS_W:1];
	assign pad_clear = (m_tdata[OUT_DATA_W-1:CROSS_W+2] == '0);

	// A stalled result holds
	`PIP_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	// One item in flight: no second transfer right behind the first
	`PIP_ASSERT_NXT(a_one_item, s_tvalid && s_tready && $stable(s_tuser) && $stable(s_tdata), !s_tready)
	// Inside is the count's parity unless the count saturated
	`PIP_ASSERT_IMP(a_parity, m_tvalid && (cross_cnt != '1), m_tdata[0] == cross_cnt[0])
	// A dropped append reports no crossings and leaves the padding clear
	`PIP_ASSERT_IMP(a_drop_clean, m_tvalid && m_tdata[CROSS_W+1], (cross_cnt == '0) && !m_tdata[0] && pad_clear)

endmodule

bind point_in_polygon_test pip_chk u_pip_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

>>> tb/tb_point_in_polygon_test.sv
// ----------------------------------------------------------------------------
// tb_point_in_polygon_test
// Drives clear, append, query and reserved-code transfers into the
// point-in-polygon block and checks each result against a crossing-number
// predictor kept in a scoreboard, with random gaps on the input stream and
// random stalls on the output stream.
// ----------------------------------------------------------------------------
module tb_point_in_polygon_test;
	timeunit 1ns;
	timeprecision 1ps;

	import pip_pkg::*;

	localparam int MAX_VERTS = 256;
	localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;
	localparam logic [COORD_W-1:0] ONE = 32'h0001_0000;
	localparam logic [COORD_W-1:0] COORD_MIN = 32'h8000_0000;
	localparam logic [COORD_W-1:0] COORD_MAX = 32'h7FFF_FFFF;
	localparam int unsigned CYCLE_LIMIT = 2000000;
	localparam int unsigned DRAIN_CYCLES = 300;

	typedef struct packed {
		logic              inside_res;
		logic [CROSS_W-1:0] crossings;
		logic              status;
	} pip_result_t;

	class outline_scoreboard;
		logic signed [COORD_W-1:0] vert_r [MAX_VERTS];
		logic signed [COORD_W-1:0] vert_z [MAX_VERTS];
		int unsigned vert_count;
		pip_result_t pending_results[$];
		int unsigned errors;

		function new();
			vert_count = 0;
			errors = 0;
		endfunction

		// Exact crossing count over the open chain of stored edges.
		function int unsigned count_crossings(logic signed [COORD_W-1:0] qr,
				logic signed [COORD_W-1:0] qz);
			logic signed [COORD_W:0] z1, z2, r1, r2, a, b;
			logic signed [67:0] d;
			int unsigned hits;
			hits = 0;
			for (int i = 0; i + 1 < vert_count; i++) begin
				a = vert_z[i];     b = qz; z1 = a - b;
				a = vert_z[i + 1];         z2 = a - b;
				a = vert_r[i];     b = qr; r1 = a - b;
				a = vert_r[i + 1];         r2 = a - b;
				if ((z1 > 0 && z2 < 0) || (z1 < 0 && z2 > 0)) begin
					d = z1 * r2 - r1 * z2;
					if ((z1 > 0 && d > 0) || (z1 < 0 && d < 0))
						hits++;
				end
			end
			return hits;
		endfunction

		function void note_item(logic [OP_W-1:0] op, logic signed [COORD_W-1:0] r,
				logic signed [COORD_W-1:0] z);
			pip_result_t res;
			int unsigned hits;
			res = '0;
			case (op)
				OP_CLEAR: vert_count = 0;
				OP_APPEND: begin
					if (vert_count < MAX_VERTS) begin
						vert_r[vert_count] = r;
						vert_z[vert_count] = z;
						vert_count++;
					end else begin
						res.status = 1'b1;
					end
				end
				OP_QUERY: begin
					hits = count_crossings(r, z);
					res.inside_res = hits[0];
					res.crossings = (hits > 255) ? 8'hFF : hits[CROSS_W-1:0];
				end
				default: ;
			endcase
			pending_results.push_back(res);
		endfunction

		function void check_result(logic [OUT_DATA_W-1:0] data);
			pip_result_t want;
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("result %h with nothing pending", data);
				return;
			end
			want = pending_results.pop_front();
			if (data[0] !== want.inside_res || data[CROSS_W:1] !== want.crossings ||
					data[CROSS_W+1] !== want.status || data[OUT_DATA_W-1:CROSS_W+2] !== '0) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: inside %b/%b crossings %0d/%0d status %b/%b pad %h",
						want.inside_res, data[0], want.crossings, data[CROSS_W:1],
						want.status, data[CROSS_W+1], data[OUT_DATA_W-1:CROSS_W+2]);
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [OP_W-1:0]       s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;

	logic [31:0] cycle_count = '0;
	int unsigned stall_left = 0;
	int unsigned items_sent = 0;
	outline_scoreboard sb = new();

	point_in_polygon_test #(
		.MAX_VERTICES(MAX_VERTS)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_point_in_polygon_test: errors");
			$finish;
		end
	end

	// While cycle_count[11:10] is zero (one quarter of the time), no new input gaps or output stalls start.
	function automatic logic idle_free();
		return cycle_count[11:10] == 2'd0;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned p;
		p = $urandom_range(0, 99);
		if (p < 55)
			return 0;
		else if (p < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 50);
	endfunction

	function automatic logic [COORD_W-1:0] pick_coord(int unsigned mode);
		case (mode)
			0: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
			1: return $urandom;
			default: begin
				case ($urandom_range(0, 4))
					0: return COORD_MIN;
					1: return COORD_MAX;
					2: return '0;
					3: return '1;
					default: return ONE;
				endcase
			end
		endcase
	endfunction

	// Output side: random stalls, mostly short.
	always @(posedge clk) begin
		if (stall_left != 0) begin
			m_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (idle_free() || $urandom_range(0, 99) >= 35) begin
			m_tready <= 1'b1;
		end else begin
			m_tready <= 1'b0;
			stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) :
				$urandom_range(0, 2);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata);
	end

	task automatic send_item(input logic [OP_W-1:0] op, input logic [COORD_W-1:0] r,
			input logic [COORD_W-1:0] z);
		int unsigned gap;
		gap = idle_free() ? 0 : pick_gap();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {z, r};
		s_tuser <= op;
		do @(posedge clk); while (!s_tready);
		sb.note_item(op, r, z);
		if (op != OP_RESERVED)
			items_sent++;
	endtask

	task automatic run_directed();
		send_item(OP_QUERY, '0, '0);
		send_item(OP_RESERVED, $urandom, $urandom);
		send_item(OP_APPEND, ONE, ONE);
		send_item(OP_QUERY, '0, '0);
		send_item(OP_CLEAR, '0, '0);
		// unit square, closed by repeating the first corner
		send_item(OP_APPEND, ONE, ONE);
		send_item(OP_APPEND, -ONE, ONE);
		send_item(OP_APPEND, -ONE, -ONE);
		send_item(OP_APPEND, ONE, -ONE);
		send_item(OP_APPEND, ONE, ONE);
		send_item(OP_QUERY, '0, '0);
		send_item(OP_QUERY, '0, ONE);
		send_item(OP_QUERY, 2 * ONE, '0);
		send_item(OP_QUERY, -2 * ONE, '0);
		send_item(OP_QUERY, COORD_MAX, COORD_MIN);
		send_item(OP_QUERY, COORD_MIN, COORD_MAX);
		send_item(OP_CLEAR, COORD_MAX, COORD_MIN);
		send_item(OP_APPEND, COORD_MAX, COORD_MAX);
		send_item(OP_APPEND, COORD_MIN, COORD_MAX);
		send_item(OP_APPEND, COORD_MIN, COORD_MIN);
		send_item(OP_APPEND, COORD_MAX, COORD_MIN);
		send_item(OP_APPEND, COORD_MAX, COORD_MAX);
		send_item(OP_QUERY, '0, '0);
		send_item(OP_QUERY, COORD_MIN, '0);
	endtask

	// Optionally clear, build an open or closed outline, then query around it.
	task automatic send_outline(input int unsigned mode, input logic closed,
			input logic with_clear);
		logic [COORD_W-1:0] pr[$];
		logic [COORD_W-1:0] pz[$];
		logic [COORD_W-1:0] r, z;
		int unsigned k, idx, sel;
		if (with_clear)
			send_item(OP_CLEAR, pick_coord(1), pick_coord(1));
		k = $urandom_range(2, 12);
		repeat (k) begin
			r = pick_coord(mode);
			z = pick_coord(mode);
			pr.push_back(r);
			pz.push_back(z);
			send_item(OP_APPEND, r, z);
		end
		if (closed)
			send_item(OP_APPEND, pr[0], pz[0]);
		repeat ($urandom_range(2, 6)) begin
			sel = $urandom_range(0, 99);
			idx = $urandom_range(0, pr.size() - 1);
			if (sel < 60) begin
				r = pick_coord(mode);
				z = pick_coord(mode);
			end else if (sel < 85) begin
				r = pick_coord(mode);
				z = pz[idx];
			end else begin
				r = pr[idx];
				z = pz[idx];
			end
			send_item(OP_QUERY, r, z);
		end
	endtask

	task automatic send_noise();
		repeat ($urandom_range(3, 10))
			send_item(OP_W'($urandom_range(0, 3)), $urandom, $urandom);
	endtask

	task automatic run_random(input int unsigned count);
		int unsigned target, p, mode;
		target = items_sent + count;
		while (items_sent < target) begin
			p = $urandom_range(0, 99);
			mode = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 2);
			if (p < 75)
				send_outline(mode, 1'b1, 1'b1);
			else if (p < 87)
				send_outline(mode, 1'b0, 1'($urandom_range(0, 1)));
			else
				send_noise();
		end
	endtask

	// Fill every vertex slot, push past full, query the full outline.
	task automatic fill_store(input logic zigzag);
		logic [COORD_W-1:0] r, z;
		send_item(OP_CLEAR, '0, '0);
		for (int i = 0; i < MAX_VERTS; i++) begin
			if (zigzag) begin
				r = ONE * (i + 1);
				z = i[0] ? -ONE : ONE;
			end else begin
				r = pick_coord($urandom_range(0, 2));
				z = pick_coord($urandom_range(0, 2));
			end
			send_item(OP_APPEND, r, z);
		end
		repeat (2) send_item(OP_APPEND, pick_coord(1), pick_coord(1));
		send_item(OP_QUERY, '0, '0);
		send_item(OP_QUERY, ONE * 300, '0);
		send_item(OP_QUERY, ONE * 128 + (ONE >> 1), '0);
		send_item(OP_QUERY, '0, ONE);
		repeat (3) send_item(OP_QUERY, pick_coord(0), pick_coord(0));
		send_item(OP_RESERVED, $urandom, $urandom);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		run_random(60);
		fill_store(1'b1);
		run_random(60);
		fill_store(1'b0);
		run_random(60);
		s_tvalid <= 1'b0;
		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending_results.size() == 0) begin
			$display("tb_point_in_polygon_test: clean");
		end else begin
			$display("tb_point_in_polygon_test: errors");
		end
		$finish;
	end

endmodule
